// ===== sv/stimulation_session_controller_macros.svh =====
// ---------------------------------------------------------------------------
// stimulation session controller assertion macros
// shared property forms for the port checker
// ---------------------------------------------------------------------------
`ifndef STIMULATION_SESSION_CONTROLLER_MACROS_SVH
`define STIMULATION_SESSION_CONTROLLER_MACROS_SVH

// same-cycle implication, disabled during reset
`define SSC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ssc_pkg.sv =====
// ---------------------------------------------------------------------------
// ssc_pkg
// types, codes and constants of the stimulation session controller
// ---------------------------------------------------------------------------
`default_nettype none

package ssc_pkg;

  localparam int CUR_W  = 16;  // current field width in microamps
  localparam int MIN_W  = 7;
  localparam int SEC_W  = 6;
  localparam int STEP_W = 12;
  localparam int EV_W   = 3;
  localparam int IDX_W  = 3;
  localparam int CFG_W  = 16;

  localparam logic [SEC_W-1:0]  SEC_LAST      = SEC_W'(59);
  localparam logic [MIN_W-1:0]  MINUTES_RESET = MIN_W'(18);
  localparam logic [CUR_W-1:0]  CURRENT_RESET = CUR_W'(1000);

  localparam logic [MIN_W-1:0]  MINUTES_MIN_RESET = MIN_W'(1);
  localparam logic [MIN_W-1:0]  MINUTES_MAX_RESET = MIN_W'(60);
  localparam logic [STEP_W-1:0] STEP_RESET        = STEP_W'(100);
  localparam logic [CUR_W-1:0]  CUR_MIN_RESET     = CUR_W'(100);
  localparam logic [CUR_W-1:0]  CUR_MAX_RESET     = CUR_W'(2000);
  localparam logic [CUR_W-1:0]  MARGIN_RESET      = CUR_W'(504);

  typedef enum logic [1:0] {
    RUN_IDLE    = 2'd0,
    RUN_ACTIVE  = 2'd1,
    RUN_STANDBY = 2'd2
  } run_mode_t;

  typedef enum logic [EV_W-1:0] {
    EV_START      = 3'd0,
    EV_START_LONG = 3'd1,
    EV_MIN_UP     = 3'd2,
    EV_MIN_DOWN   = 3'd3,
    EV_CUR_UP     = 3'd4,
    EV_CUR_DOWN   = 3'd5,
    EV_TICK       = 3'd6,
    EV_MEASURE    = 3'd7
  } event_t;

  typedef enum logic [2:0] {
    BEEP_NONE    = 3'd0,
    BEEP_OK      = 3'd1,
    BEEP_ERR     = 3'd2,
    BEEP_START   = 3'd3,
    BEEP_STOP    = 3'd4,
    BEEP_STANDBY = 3'd5,
    BEEP_WAKE    = 3'd6
  } beep_t;

  typedef enum logic [IDX_W-1:0] {
    CFG_MINUTES_MIN = 3'd0,
    CFG_MINUTES_MAX = 3'd1,
    CFG_CUR_STEP    = 3'd2,
    CFG_CUR_MIN     = 3'd3,
    CFG_CUR_MAX     = 3'd4,
    CFG_OC_MARGIN   = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic [MIN_W-1:0]  mins_lo;
    logic [MIN_W-1:0]  mins_hi;
    logic [STEP_W-1:0] cur_step;
    logic [CUR_W-1:0]  cur_lo;
    logic [CUR_W-1:0]  cur_hi;
    logic [CUR_W-1:0]  overcurrent_margin_ua;
  } cfg_t;

  typedef struct packed {
    run_mode_t         mode;
    logic [MIN_W-1:0]  minutes_set;
    logic [CUR_W-1:0]  current_set;
    logic [MIN_W-1:0]  minutes_left;
    logic [SEC_W-1:0]  seconds_left;
  } sess_state_t;

  // last member sits in the lowest bits
  typedef struct packed {
    logic              fault;
    beep_t             beep_code;
    logic              output_enable;
    logic [SEC_W-1:0]  seconds_left;
    logic [MIN_W-1:0]  minutes_left;
    logic [CUR_W-1:0]  current_setpoint_ua;
    logic [MIN_W-1:0]  minutes_setpoint;
    run_mode_t         run_state;
  } result_t;

  localparam int RES_W = $bits(result_t);
  localparam int OUT_W = ((RES_W + 7) / 8) * 8;

endpackage

`default_nettype wire

// ===== sv/ssc_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// ssc_cfg_regs
// limit and step registers written through the plain write port
// ---------------------------------------------------------------------------
`default_nettype none

module ssc_cfg_regs import ssc_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mins_lo               <= MINUTES_MIN_RESET;
      cfg.mins_hi               <= MINUTES_MAX_RESET;
      cfg.cur_step              <= STEP_RESET;
      cfg.cur_lo                <= CUR_MIN_RESET;
      cfg.cur_hi                <= CUR_MAX_RESET;
      cfg.overcurrent_margin_ua <= MARGIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MINUTES_MIN: cfg.mins_lo               <= cfg_data[MIN_W-1:0];
        CFG_MINUTES_MAX: cfg.mins_hi               <= cfg_data[MIN_W-1:0];
        CFG_CUR_STEP:    cfg.cur_step              <= cfg_data[STEP_W-1:0];
        CFG_CUR_MIN:     cfg.cur_lo                <= cfg_data[CUR_W-1:0];
        CFG_CUR_MAX:     cfg.cur_hi                <= cfg_data[CUR_W-1:0];
        CFG_OC_MARGIN:   cfg.overcurrent_margin_ua <= cfg_data[CUR_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/ssc_step.sv =====
// ---------------------------------------------------------------------------
// ssc_step
// next session state, beep code and fault flag for one event
// ---------------------------------------------------------------------------
`default_nettype none

module ssc_step import ssc_pkg::*; (
  input  wire event_t           ev,
  input  wire logic [CUR_W-1:0] measured_ua,
  input  wire sess_state_t      st,
  input  wire cfg_t             cfg,
  output sess_state_t           st_next,
  output beep_t                 beep,
  output logic                  fault
);

  logic              is_idle;
  logic              is_active;
  logic [CUR_W:0]    step_ext;
  logic [CUR_W:0]    cur_sum;
  logic [CUR_W:0]    cur_diff;
  logic              cur_up_ok;
  logic              cur_down_ok;
  logic [CUR_W:0]    meas_diff;
  logic              overcurrent;
  logic              time_nonzero;
  logic [MIN_W-1:0]  tick_min;
  logic [SEC_W-1:0]  tick_sec;
  logic              tick_at_zero;
  run_mode_t         mode_next;

  assign is_idle   = (st.mode == RUN_IDLE);
  assign is_active = (st.mode == RUN_ACTIVE);

  assign step_ext    = {{(CUR_W + 1 - STEP_W){1'b0}}, cfg.cur_step};
  assign cur_sum     = {1'b0, st.current_set} + step_ext;
  assign cur_up_ok   = (cur_sum <= {1'b0, cfg.cur_hi});
  // borrow out means the step went below zero
  assign cur_diff    = {1'b0, st.current_set} - step_ext;
  assign cur_down_ok = !cur_diff[CUR_W] && (cur_diff[CUR_W-1:0] >= cfg.cur_lo);

  // measured below set never exceeds a non-negative margin
  assign meas_diff   = {1'b0, measured_ua} - {1'b0, st.current_set};
  assign overcurrent = !meas_diff[CUR_W] &&
                       (meas_diff[CUR_W-1:0] > cfg.overcurrent_margin_ua);

  assign time_nonzero = (st.minutes_left != '0) || (st.seconds_left != '0);

  always_comb begin
    tick_min = st.minutes_left;
    tick_sec = st.seconds_left;
    if (time_nonzero) begin
      if (st.seconds_left == '0) begin
        tick_sec = SEC_LAST;
        tick_min = st.minutes_left - MIN_W'(1);
      end else begin
        tick_sec = st.seconds_left - SEC_W'(1);
      end
    end
  end

  assign tick_at_zero = (tick_min == '0) && (tick_sec == '0);

  // next mode
  always_comb begin
    mode_next = st.mode;
    case (ev)
      EV_START: begin
        if (is_idle) begin
          mode_next = RUN_ACTIVE;
        end else if (is_active) begin
          mode_next = RUN_IDLE;
        end
      end
      EV_START_LONG: begin
        mode_next = (st.mode == RUN_STANDBY) ? RUN_IDLE : RUN_STANDBY;
      end
      EV_TICK: begin
        if (is_active && tick_at_zero) begin
          mode_next = RUN_IDLE;
        end
      end
      EV_MEASURE: begin
        if (is_active && overcurrent) begin
          mode_next = RUN_IDLE;
        end
      end
      default: begin
      end
    endcase
  end

  // setpoints, countdown, beep and fault
  always_comb begin
    st_next.mode         = mode_next;
    st_next.minutes_set  = st.minutes_set;
    st_next.current_set  = st.current_set;
    st_next.minutes_left = st.minutes_left;
    st_next.seconds_left = st.seconds_left;
    beep  = BEEP_NONE;
    fault = 1'b0;
    case (ev)
      EV_START: begin
        if (is_idle) begin
          beep                 = BEEP_START;
          st_next.minutes_left = st.minutes_set;
          st_next.seconds_left = '0;
        end else if (is_active) begin
          beep = BEEP_STOP;
        end
      end
      EV_START_LONG: begin
        beep = (st.mode == RUN_STANDBY) ? BEEP_WAKE : BEEP_STANDBY;
      end
      EV_MIN_UP: begin
        if (is_idle) begin
          if (st.minutes_set < cfg.mins_hi) begin
            st_next.minutes_set = st.minutes_set + MIN_W'(1);
            beep                = BEEP_OK;
          end else begin
            beep = BEEP_ERR;
          end
        end
      end
      EV_MIN_DOWN: begin
        if (is_idle) begin
          if (st.minutes_set > cfg.mins_lo) begin
            st_next.minutes_set = st.minutes_set - MIN_W'(1);
            beep                = BEEP_OK;
          end else begin
            beep = BEEP_ERR;
          end
        end
      end
      EV_CUR_UP: begin
        if (is_idle) begin
          if (cur_up_ok) begin
            st_next.current_set = cur_sum[CUR_W-1:0];
            beep                = BEEP_OK;
          end else begin
            beep = BEEP_ERR;
          end
        end
      end
      EV_CUR_DOWN: begin
        if (is_idle) begin
          if (cur_down_ok) begin
            st_next.current_set = cur_diff[CUR_W-1:0];
            beep                = BEEP_OK;
          end else begin
            beep = BEEP_ERR;
          end
        end
      end
      EV_TICK: begin
        if (is_active) begin
          st_next.minutes_left = tick_min;
          st_next.seconds_left = tick_sec;
          if (tick_at_zero) begin
            beep = BEEP_STOP;
          end
        end
      end
      EV_MEASURE: begin
        if (is_active && overcurrent) begin
          beep  = BEEP_STOP;
          fault = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/stimulation_session_controller.sv =====
// ---------------------------------------------------------------------------
// stimulation_session_controller
// session mode, setpoints and countdown driven by key, tick and measure events
// ---------------------------------------------------------------------------
// Takes one event per clock while s_tready is high and returns exactly one
// status word per event. An accepted event lands in an input register; once
// the output register is free, its state update (mode, setpoints, countdown)
// is applied and its status word is loaded into the output register in the
// same cycle, so a new event can follow every cycle while m_tready stays
// high. While a finished word waits on m_tready the input register can take
// one more event, after which s_tready stays low until the word is taken.
// Config writes are meant for idle periods only.
`default_nettype none

module stimulation_session_controller import ssc_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  // config write port
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  // event stream
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [CUR_W-1:0] s_tdata,   // measured_ua[15:0]
  input  wire logic [EV_W-1:0]  s_tuser,   // event[2:0]
  // status stream
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  // run_state[1:0], minutes_setpoint[8:2], current_setpoint_ua[24:9],
  // minutes_left[31:25], seconds_left[37:32], output_enable[38],
  // beep_code[41:39], fault[42], zero fill[47:43]
  output logic [OUT_W-1:0]      m_tdata
);

  cfg_t              cfg;
  logic              in_valid;
  event_t            in_ev;
  logic [CUR_W-1:0]  in_meas;
  logic              out_free;
  logic              advance;
  sess_state_t       st;
  sess_state_t       st_next;
  beep_t             beep;
  logic              fault;
  result_t           res;

  ssc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = !in_valid || out_free;
  assign advance  = in_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_ev   <= event_t'(s_tuser);
      in_meas <= s_tdata;
    end
  end

  ssc_step u_step (
    .ev          (in_ev),
    .measured_ua (in_meas),
    .st          (st),
    .cfg         (cfg),
    .st_next     (st_next),
    .beep        (beep),
    .fault       (fault)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode         <= RUN_IDLE;
      st.minutes_set  <= MINUTES_RESET;
      st.current_set  <= CURRENT_RESET;
      st.minutes_left <= '0;
      st.seconds_left <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res.run_state           <= st_next.mode;
      res.minutes_setpoint    <= st_next.minutes_set;
      res.current_setpoint_ua <= st_next.current_set;
      res.minutes_left        <= st_next.minutes_left;
      res.seconds_left        <= st_next.seconds_left;
      res.output_enable       <= (st_next.mode == RUN_ACTIVE);
      res.beep_code           <= beep;
      res.fault               <= fault;
    end
  end

  assign m_tdata = {{(OUT_W - RES_W){1'b0}}, res};

endmodule

`default_nettype wire

// ===== sv/ssc_checker.sv =====
// ---------------------------------------------------------------------------
// ssc_checker
// port-level checks of the status stream, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "stimulation_session_controller_macros.svh"

module ssc_checker import ssc_pkg::*; (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             m_tvalid,
  input wire logic             m_tready,
  input wire logic [OUT_W-1:0] m_tdata
);

  result_t r;

  assign r = result_t'(m_tdata[RES_W-1:0]);

  // output enable follows the running mode in every word
  `SSC_ASSERT_SAME(a_enable_tracks_mode, m_tvalid,
                   r.output_enable == (r.run_state == RUN_ACTIVE),
                   "output_enable disagrees with run_state")

  // an overcurrent stop leaves the block idle with a stop beep
  `SSC_ASSERT_SAME(a_fault_stops, m_tvalid && r.fault,
                   (r.run_state == RUN_IDLE) && (r.beep_code == BEEP_STOP) && !r.output_enable,
                   "fault word without a stop")

  // countdown seconds stay within one minute
  `SSC_ASSERT_SAME(a_seconds_range, m_tvalid, r.seconds_left <= SEC_LAST,
                   "seconds_left out of range")

  `SSC_ASSERT_NEXT(a_hold_stalled, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
                   "stalled status word changed")

endmodule

bind stimulation_session_controller ssc_checker u_ssc_checker (.*);

`default_nettype wire
